// ===== src/gb_pkg.sv =====
// Shared constants, types and sizes for the 3x3 Gaussian blur block.
// No dependencies; every other file imports this package.
package gb_pkg;

   localparam int FRAME_WIDTH  = 8;
   localparam int FRAME_HEIGHT = 8;

   localparam int PIX_W      = 8;
   localparam int COL_W      = $clog2(FRAME_WIDTH);
   localparam int ROW_W      = $clog2(FRAME_HEIGHT);
   localparam int HIST_DEPTH = 2 * FRAME_WIDTH + 2;
   localparam int FLUSH_LEN  = FRAME_WIDTH + 1;
   localparam int FLUSH_W    = $clog2(FLUSH_LEN + 1);
   localparam int SUM_W      = PIX_W + 4;
   localparam int KERNEL_N   = 9;

   typedef logic [PIX_W-1:0] pixel_type;

   // Control of one pixel cell: load has priority over shift.
   typedef struct packed {
      logic shift;
      logic load;
   } gb_cell_ctrl_type;

endpackage

// ===== src/gb_stream_if.sv =====
// Valid/ready channel interfaces for the blur block's pixel input and result output.
// Depends on gb_pkg for the pixel type.
interface gb_req_if;
   import gb_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface gb_rsp_if;
   import gb_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type pixel_out;
   logic      frame_last;
   logic      run_last;

   modport source (output valid, output pixel_out, output frame_last, output run_last,
                   input ready);
   modport sink   (input valid, input pixel_out, input frame_last, input run_last,
                   output ready);
endinterface

// ===== src/gb_cell.sv =====
// One pixel cell of a shift chain: holds a pixel, takes its neighbor's on shift.
// Depends on gb_pkg.
module gb_cell (
   input  logic                     clock,
   input  gb_pkg::gb_cell_ctrl_type ctrl,
   input  gb_pkg::pixel_type        load_data,
   input  gb_pkg::pixel_type        shift_data,
   output gb_pkg::pixel_type        pixel
);
   import gb_pkg::*;

   pixel_type pix_ff;
   pixel_type pix_in;

   always_comb begin
      priority if (ctrl.load) begin
         pix_in = load_data;
      end else if (ctrl.shift) begin
         pix_in = shift_data;
      end else begin
         pix_in = pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign pixel = pix_ff;

endmodule

// ===== src/gb_kernel.sv =====
// Weighted 3x3 sum (1 2 1; 2 4 2; 1 2 1) shifted right by four, truncated.
// Depends on gb_pkg. Window order: top row left to right, then middle, then bottom.
module gb_kernel (
   input  gb_pkg::pixel_type win [gb_pkg::KERNEL_N],
   output gb_pkg::pixel_type blurred
);
   import gb_pkg::*;

   logic [SUM_W-1:0] sum;

   always_comb begin
      sum = SUM_W'(win[0])        + (SUM_W'(win[1]) << 1) + SUM_W'(win[2])
          + (SUM_W'(win[3]) << 1) + (SUM_W'(win[4]) << 2) + (SUM_W'(win[5]) << 1)
          + SUM_W'(win[6])        + (SUM_W'(win[7]) << 1) + SUM_W'(win[8]);
   end

   assign blurred = sum[SUM_W-1:4];

endmodule

// ===== src/gaussian_blur_3x3.sv =====
// Top level of the 3x3 Gaussian blur: line history chain, flush chain, output register.
// Depends on gb_pkg, gb_stream_if, gb_cell and gb_kernel.
//
// Takes one pixel per clock in raster order, frames back to back, and gives one
// result per clock. Output pixel k is offered in the cycle after input pixel
// k+FRAME_WIDTH+1 is transferred; the first FRAME_WIDTH+1 inputs of a frame give
// nothing. The last input of a frame gives its own result and then the last
// FRAME_WIDTH+1 pixels unchanged, taken from a flush chain loaded at that
// transfer, while the next frame's first inputs keep flowing in. Border pixels
// pass through unchanged; frame_last marks the final pixel of a frame and
// run_last the last result of each input. The single output register sets the
// rate: an input that yields a result is taken when that register is free and
// the flush chain is empty; other inputs are always taken.
module gaussian_blur_3x3 (
   input logic      clock,
   input logic      reset,
   gb_req_if.sink   req_chan,
   gb_rsp_if.source rsp_chan
);
   import gb_pkg::*;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [FLUSH_W-1:0] flush_cnt_ff, flush_cnt_in;

   logic      out_valid_ff, out_valid_in;
   pixel_type out_pix_ff, out_pix_in;
   logic      out_flast_ff, out_flast_in;
   logic      out_rlast_ff, out_rlast_in;

   logic      accept;
   logic      produces;
   logic      is_border;
   logic      is_last_in;
   logic      slot_free;
   logic      flush_adv;
   pixel_type cur;
   pixel_type blurred;
   pixel_type hist_pix  [HIST_DEPTH];
   pixel_type flush_pix [FLUSH_LEN];
   pixel_type win       [KERNEL_N];

   gb_cell_ctrl_type hist_ctrl;
   gb_cell_ctrl_type flush_ctrl;

   assign cur        = req_chan.pixel_in;
   assign is_last_in = (row_ff == ROW_W'(FRAME_HEIGHT - 1)) &&
                       (col_ff == COL_W'(FRAME_WIDTH - 1));
   assign produces   = (row_ff >= ROW_W'(2)) ||
                       ((row_ff == ROW_W'(1)) && (col_ff != '0));
   // Output pixel sits one row and one column back; only these spots hit the border.
   assign is_border  = (col_ff == COL_W'(0)) || (col_ff == COL_W'(1)) ||
                       (row_ff == ROW_W'(1));
   assign slot_free  = !out_valid_ff || rsp_chan.ready;
   assign flush_adv  = slot_free && (flush_cnt_ff != '0);

   assign req_chan.ready = !produces || (slot_free && (flush_cnt_ff == '0));
   assign accept         = req_chan.valid && req_chan.ready;

   // Line history: cell 0 holds the previous pixel, each cell passes to the next.
   assign hist_ctrl = '{shift: accept, load: 1'b0};

   for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_hist
      if (i == 0) begin : g_head
         gb_cell u_cell (
            .clock      (clock),
            .ctrl       (hist_ctrl),
            .load_data  (cur),
            .shift_data (cur),
            .pixel      (hist_pix[i])
         );
      end else begin : g_body
         gb_cell u_cell (
            .clock      (clock),
            .ctrl       (hist_ctrl),
            .load_data  (hist_pix[i-1]),
            .shift_data (hist_pix[i-1]),
            .pixel      (hist_pix[i])
         );
      end
   end

   // Flush chain: loaded with the frame's last FRAME_WIDTH+1 pixels, oldest in cell 0.
   assign flush_ctrl = '{shift: flush_adv, load: accept && is_last_in};

   for (genvar m = 0; m < FLUSH_LEN; m++) begin : g_flush
      if (m == FLUSH_LEN - 1) begin : g_tail
         gb_cell u_cell (
            .clock      (clock),
            .ctrl       (flush_ctrl),
            .load_data  (cur),
            .shift_data ('0),
            .pixel      (flush_pix[m])
         );
      end else begin : g_body
         gb_cell u_cell (
            .clock      (clock),
            .ctrl       (flush_ctrl),
            .load_data  (hist_pix[FRAME_WIDTH-m-1]),
            .shift_data (flush_pix[m+1]),
            .pixel      (flush_pix[m])
         );
      end
   end

   assign win[0] = hist_pix[2*FRAME_WIDTH+1];
   assign win[1] = hist_pix[2*FRAME_WIDTH];
   assign win[2] = hist_pix[2*FRAME_WIDTH-1];
   assign win[3] = hist_pix[FRAME_WIDTH+1];
   assign win[4] = hist_pix[FRAME_WIDTH];
   assign win[5] = hist_pix[FRAME_WIDTH-1];
   assign win[6] = hist_pix[1];
   assign win[7] = hist_pix[0];
   assign win[8] = cur;

   gb_kernel u_kernel (
      .win     (win),
      .blurred (blurred)
   );

   // Raster counters wrap at frame end.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff == COL_W'(FRAME_WIDTH - 1)) begin
            col_in = '0;
            if (row_ff == ROW_W'(FRAME_HEIGHT - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      flush_cnt_in = flush_cnt_ff;
      out_valid_in = out_valid_ff;
      out_pix_in   = out_pix_ff;
      out_flast_in = out_flast_ff;
      out_rlast_in = out_rlast_ff;
      if (accept && is_last_in) begin
         flush_cnt_in = FLUSH_W'(FLUSH_LEN);
      end else if (flush_adv) begin
         flush_cnt_in = flush_cnt_ff - FLUSH_W'(1);
      end
      if (slot_free) begin
         priority if (flush_cnt_ff != '0) begin
            out_valid_in = 1'b1;
            out_pix_in   = flush_pix[0];
            out_flast_in = (flush_cnt_ff == FLUSH_W'(1));
            out_rlast_in = (flush_cnt_ff == FLUSH_W'(1));
         end else if (accept && produces) begin
            out_valid_in = 1'b1;
            out_pix_in   = is_border ? hist_pix[FRAME_WIDTH] : blurred;
            out_flast_in = 1'b0;
            out_rlast_in = !is_last_in;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         flush_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         flush_cnt_ff <= flush_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pix_ff   <= out_pix_in;
      out_flast_ff <= out_flast_in;
      out_rlast_ff <= out_rlast_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pixel_out  = out_pix_ff;
   assign rsp_chan.frame_last = out_flast_ff;
   assign rsp_chan.run_last   = out_rlast_ff;

   a_flush_start: assert property (@(posedge clock) disable iff (reset)
      (accept && is_last_in) |=> (flush_cnt_ff == FLUSH_W'(FLUSH_LEN)) && out_valid_ff)
      else $error("flush did not start after last pixel of frame");

   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      (flush_cnt_ff != '0) |-> out_valid_ff)
      else $error("output register empty while flushing");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (accept && produces) |-> (flush_cnt_ff == '0))
      else $error("result transfer taken during flush");

   a_flast_rlast: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_flast_ff) |-> out_rlast_ff)
      else $error("frame_last without run_last");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(FRAME_WIDTH - 1))
      else $error("column counter out of range");

endmodule
